// File: hw/rtl/sdmd_pkg.sv
// Shared types and constants for the sigma-delta motion detector.
// No dependencies; imported by sdmd_update, sigma_delta_motion_detect and the bench.
`timescale 1ns / 1ps

package sdmd_pkg;

    localparam int FRAME_PIXELS_DEF = 65536;
    localparam int PIX_W            = 8;
    localparam int ADDR_IN_W        = 16;
    localparam int GAIN_W           = 4;

    // Register map, index = paddr[3:2]
    localparam logic [1:0] REG_GAIN    = 2'd0;
    localparam logic [1:0] REG_VAR_MIN = 2'd1;
    localparam logic [1:0] REG_VAR_MAX = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RST    = 4'd2;
    localparam logic [PIX_W-1:0]  VAR_MIN_RST = 8'd1;
    localparam logic [PIX_W-1:0]  VAR_MAX_RST = 8'd254;
    localparam logic [PIX_W-1:0]  VAR_INIT    = 8'd1;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [PIX_W-1:0]  var_min;
        logic [PIX_W-1:0]  var_max;
    } cfg_t;

    // One word of the background store
    typedef struct packed {
        logic [PIX_W-1:0] mean;
        logic [PIX_W-1:0] variance;
    } entry_t;

    typedef struct packed {
        entry_t           entry;
        logic             motion;
        logic [PIX_W-1:0] abs_difference;
    } upd_t;

endpackage

// File: hw/rtl/sigma_delta_motion_detect.sv
// Sigma-delta motion detector top level: APB registers, background store with read-modify-write
// and forwarding, result register. Depends on sdmd_pkg and sdmd_update.
// Throughput: one pixel per clock; store write-back of one pixel and read of the next share an
// edge (simple dual-port store). A stalled result holds the whole pipe.
// Stages A (input), B (store read, update), result register. Reset: pipeline valids and
// registers to defaults; store not cleared, and the user must write it before use (unchecked).
`timescale 1ns / 1ps

module sigma_delta_motion_detect #(
    parameter int FRAME_PIXELS = sdmd_pkg::FRAME_PIXELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // pixel input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [sdmd_pkg::PIX_W-1:0]     pixel,
    input  logic [sdmd_pkg::ADDR_IN_W-1:0] pixel_addr,
    input  logic                           init_frame,
    // result output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           motion,
    output logic [sdmd_pkg::PIX_W-1:0]     abs_difference
);
    import sdmd_pkg::*;

    localparam int  ADDR_W   = $clog2(FRAME_PIXELS);
    // Input addresses only wrap when the frame is smaller than the address span
    localparam bit  NEED_MOD = FRAME_PIXELS < (1 << ADDR_IN_W);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cfg_t cfg_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain    <= GAIN_RST;
            cfg_reg.var_min <= VAR_MIN_RST;
            cfg_reg.var_max <= VAR_MAX_RST;
        end
        else if (cfg_wr)
        begin
            // writes past the last register are dropped
            unique case (paddr[3:2])
                REG_GAIN:    cfg_reg.gain    <= pwdata[GAIN_W-1:0];
                REG_VAR_MIN: cfg_reg.var_min <= pwdata[PIX_W-1:0];
                REG_VAR_MAX: cfg_reg.var_max <= pwdata[PIX_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_GAIN:    prdata = 32'(cfg_reg.gain);
            REG_VAR_MIN: prdata = 32'(cfg_reg.var_min);
            REG_VAR_MAX: prdata = 32'(cfg_reg.var_max);
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: the whole pipe moves together whenever the result
    // register is empty or being taken. Bubbles travel as cleared valids.
    // ------------------------------------------------------------------
    logic advance;
    logic accept;
    logic out_valid_reg;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    // ------------------------------------------------------------------
    // Stage A: registered input, frame slot computed from the address
    // ------------------------------------------------------------------
    logic                 a_valid_reg;
    logic [PIX_W-1:0]     a_pix_reg;
    logic [ADDR_IN_W-1:0] a_addr_reg;
    logic                 a_init_reg;
    logic [ADDR_W-1:0]    a_slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (advance)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pix_reg  <= pixel;
            a_addr_reg <= pixel_addr;
            a_init_reg <= init_frame;
        end
    end

    generate
        if (NEED_MOD)
        begin : g_wrap
            // addr mod N via reciprocal: quotient from the input transfer,
            // registered, then remainder with a single correcting subtract
            localparam logic [28:0] RECIP =
                29'(((64'd1 << 32) + 64'(FRAME_PIXELS) - 64'd1) / 64'(FRAME_PIXELS));

            logic [47:0]          q_prod;
            logic [ADDR_IN_W-1:0] a_q_reg;
            logic [31:0]          qn;
            logic [ADDR_IN_W:0]   rem_raw;
            logic [ADDR_IN_W:0]   rem_fix;

            assign q_prod = 48'(pixel_addr) * 48'(RECIP);

            always_ff @(posedge clk)
            begin
                if (accept)
                    a_q_reg <= q_prod[47:32];
            end

            assign qn      = 32'(a_q_reg) * 32'(FRAME_PIXELS);
            assign rem_raw = {1'b0, a_addr_reg} - qn[ADDR_IN_W:0];
            assign rem_fix = (rem_raw >= 17'(FRAME_PIXELS)) ?
                             (rem_raw - 17'(FRAME_PIXELS)) : rem_raw;
            assign a_slot  = rem_fix[ADDR_W-1:0];
        end
        else
        begin : g_direct
            assign a_slot = ADDR_W'(a_addr_reg);
        end
    endgenerate

    // ------------------------------------------------------------------
    // Background store: one word per pixel {mean, variance}. Read issued as
    // a pixel leaves stage A, written back as it leaves stage B.
    // ------------------------------------------------------------------
    entry_t            store_mem [FRAME_PIXELS];
    entry_t            rd_data_reg;
    logic              b_valid_reg;
    logic [PIX_W-1:0]  b_pix_reg;
    logic              b_init_reg;
    logic [ADDR_W-1:0] b_slot_reg;
    upd_t              upd;

    always_ff @(posedge clk)
    begin
        if (advance)
            rd_data_reg <= store_mem[a_slot];
        if (advance && b_valid_reg)
            store_mem[b_slot_reg] <= upd.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (advance)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_pix_reg  <= a_pix_reg;
            b_init_reg <= a_init_reg;
            b_slot_reg <= a_slot;
        end
    end

    // Last write-back. A read on the same edge as a write to the same slot
    // returns the old word, so the most recent write is forwarded on a match.
    logic              wr_valid_reg;
    logic [ADDR_W-1:0] wr_slot_reg;
    entry_t            wr_data_reg;
    entry_t            cur_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_valid_reg <= 1'b0;
        else if (advance && b_valid_reg)
            wr_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (advance && b_valid_reg)
        begin
            wr_slot_reg <= b_slot_reg;
            wr_data_reg <= upd.entry;
        end
    end

    assign cur_entry = (wr_valid_reg && (wr_slot_reg == b_slot_reg)) ?
                       wr_data_reg : rd_data_reg;

    sdmd_update u_update (
        .cfg        (cfg_reg),
        .pixel      (b_pix_reg),
        .init_frame (b_init_reg),
        .cur        (cur_entry),
        .upd        (upd)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic             motion_reg;
    logic [PIX_W-1:0] diff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && b_valid_reg)
        begin
            motion_reg <= upd.motion;
            diff_reg   <= upd.abs_difference;
        end
    end

    assign out_valid      = out_valid_reg;
    assign motion         = motion_reg;
    assign abs_difference = diff_reg;

endmodule

// File: hw/rtl/sdmd_update.sv
// Per-pixel sigma-delta update: new mean, new variance, motion flag and absolute difference.
// Depends on sdmd_pkg (cfg_t, entry_t, upd_t).
`timescale 1ns / 1ps

module sdmd_update (
    input  sdmd_pkg::cfg_t             cfg,
    input  logic [sdmd_pkg::PIX_W-1:0] pixel,
    input  logic                       init_frame,
    input  sdmd_pkg::entry_t           cur,
    output sdmd_pkg::upd_t             upd
);
    import sdmd_pkg::*;

    logic [PIX_W-1:0]        mean_new;
    logic [PIX_W-1:0]        diff;
    logic [PIX_W+GAIN_W-1:0] amp;
    logic [PIX_W-1:0]        target;
    logic [PIX_W-1:0]        var_step;
    logic [PIX_W-1:0]        var_hi;
    logic [PIX_W-1:0]        var_new;

    always_comb
    begin
        if (cur.mean < pixel)
            mean_new = cur.mean + 8'd1;
        else if (cur.mean > pixel)
            mean_new = cur.mean - 8'd1;
        else
            mean_new = cur.mean;

        diff = (pixel > mean_new) ? (pixel - mean_new) : (mean_new - pixel);

        amp    = 12'(cfg.gain) * 12'(diff);
        target = (amp > 12'd255) ? 8'd255 : amp[PIX_W-1:0];

        if (cur.variance < target)
            var_step = cur.variance + 8'd1;
        else if (cur.variance > target)
            var_step = cur.variance - 8'd1;
        else
            var_step = cur.variance;

        // upper clamp first, lower clamp wins when the bounds cross
        var_hi  = (var_step > cfg.var_max) ? cfg.var_max : var_step;
        var_new = (var_hi < cfg.var_min) ? cfg.var_min : var_hi;

        if (init_frame)
        begin
            upd.entry.mean     = pixel;
            upd.entry.variance = VAR_INIT;
            upd.motion         = 1'b0;
            upd.abs_difference = '0;
        end
        else
        begin
            upd.entry.mean     = mean_new;
            upd.entry.variance = var_new;
            upd.motion         = !(diff < var_new);
            upd.abs_difference = diff;
        end
    end

endmodule

// File: bench/tb_sigma_delta_motion_detect.sv
// Self-checking bench for sigma_delta_motion_detect: APB register phases, directed and
// random pixel streams, and an in-bench background predictor checked against every result.
// Depends on sdmd_pkg and the sigma_delta_motion_detect RTL.
`timescale 1ns / 1ps

module tb_sigma_delta_motion_detect;

    import sdmd_pkg::*;

    localparam int PHASE_ITEMS = 155;   // random pixels queued per register setting, at least
    localparam int PIPE_DEPTH  = 3;     // input transfer to earliest result transfer
    localparam int STUCK_LIMIT = 2000;  // cycles without any transfer before giving up

    // One pixel transfer as the sender presents it
    typedef struct {
        logic [PIX_W-1:0]     pix;
        logic [ADDR_IN_W-1:0] addr;
        logic                 init;
    } pixel_item_t;

    // What the detector should report for one pixel
    typedef struct {
        logic             motion;
        logic [PIX_W-1:0] abs_difference;
    } verdict_t;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 psel           = 1'b0;
    logic                 penable        = 1'b0;
    logic                 pwrite         = 1'b0;
    logic [3:0]           paddr          = '0;
    logic [31:0]          pwdata         = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic [PIX_W-1:0]     pixel          = '0;
    logic [ADDR_IN_W-1:0] pixel_addr     = '0;
    logic                 init_frame     = 1'b0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic                 motion;
    logic [PIX_W-1:0]     abs_difference;

    sigma_delta_motion_detect u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pixel          (pixel),
        .pixel_addr     (pixel_addr),
        .init_frame     (init_frame),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .motion         (motion),
        .abs_difference (abs_difference)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: private copy of the background store and the registers.
    // Registers only change while the pipe is empty, so the shadow copy
    // is always the one in force for the pixel being predicted.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] bg_mean [0:(1 << ADDR_IN_W) - 1];
    logic [PIX_W-1:0] bg_var  [0:(1 << ADDR_IN_W) - 1];
    cfg_t             reg_shadow =
        '{gain: GAIN_RST, var_min: VAR_MIN_RST, var_max: VAR_MAX_RST};

    function automatic verdict_t update_background(input logic [PIX_W-1:0] pix,
                                                   input logic [ADDR_IN_W-1:0] addr,
                                                   input logic init);
        verdict_t         v;
        logic [PIX_W-1:0] m;
        logic [PIX_W-1:0] vr;
        logic [PIX_W-1:0] d;
        logic [PIX_W-1:0] tgt;
        logic [11:0]      prod;
        if (init)
        begin
            // initialising frame: load, no clamp, quiet result
            bg_mean[addr]      = pix;
            bg_var[addr]       = VAR_INIT;
            v.motion           = 1'b0;
            v.abs_difference   = '0;
        end
        else
        begin
            m = bg_mean[addr];
            if (m < pix)
                m = m + 8'd1;
            else if (m > pix)
                m = m - 8'd1;
            bg_mean[addr] = m;
            d    = (pix > m) ? pix - m : m - pix;
            prod = 12'(reg_shadow.gain) * 12'(d);
            tgt  = (prod > 12'd255) ? 8'hFF : prod[7:0];   // saturate gain*diff
            vr   = bg_var[addr];
            if (vr < tgt)
                vr = vr + 8'd1;
            else if (vr > tgt)
                vr = vr - 8'd1;
            // upper clamp first, lower second: crossed bounds leave var_min
            if (vr > reg_shadow.var_max)
                vr = reg_shadow.var_max;
            if (vr < reg_shadow.var_min)
                vr = reg_shadow.var_min;
            bg_var[addr]     = vr;
            v.motion         = (d < vr) ? 1'b0 : 1'b1;
            v.abs_difference = d;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus store. The generator keeps its own record of which store
    // entries have been initialised so that no pixel ever reads an entry
    // that was never written.
    // ------------------------------------------------------------------
    pixel_item_t      pixel_stream[$];
    verdict_t         pending_verdicts[$];
    bit               seeded      [0:(1 << ADDR_IN_W) - 1];
    logic [PIX_W-1:0] scene_level [0:(1 << ADDR_IN_W) - 1];
    logic [ADDR_IN_W-1:0] known_addrs[$];
    int               items_queued = 0;
    int               mismatches   = 0;

    function automatic void push_item(input int pix, input logic [ADDR_IN_W-1:0] addr,
                                      input logic init);
        pixel_item_t it;
        it.pix  = pix[PIX_W-1:0];
        it.addr = addr;
        it.init = init;
        pixel_stream.push_back(it);
        if (init && !seeded[addr])
        begin
            seeded[addr] = 1'b1;
            known_addrs.push_back(addr);
        end
        scene_level[addr] = pix[PIX_W-1:0];
        items_queued++;
    endfunction

    function automatic logic [ADDR_IN_W-1:0] any_known_addr();
        return known_addrs[$urandom_range(0, known_addrs.size() - 1)];
    endfunction

    // One burst of stimulus: a fresh initialisation, a steady scene on one
    // pixel with sensor noise and occasional scene cuts, or scattered pixels
    // across the frame.
    function automatic void queue_episode();
        int                   kind;
        int                   len;
        int                   level;
        int                   noise;
        int                   pix;
        logic [ADDR_IN_W-1:0] addr;
        kind = $urandom_range(0, 99);
        if (kind < 10 || known_addrs.size() == 0)
        begin
            addr = ADDR_IN_W'($urandom_range(0, (1 << ADDR_IN_W) - 1));
            push_item($urandom_range(0, 255), addr, 1'b1);
        end
        else if (kind < 70)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                addr = ADDR_IN_W'($urandom_range(0, (1 << ADDR_IN_W) - 1));
                push_item($urandom_range(0, 255), addr, 1'b1);
            end
            else
                addr = any_known_addr();
            level = int'(scene_level[addr]);
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50) : $urandom_range(2, 12);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                    level = ($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1)
                                                        : $urandom_range(0, 255);
                noise = $urandom_range(0, 6);
                pix   = level + noise - 3;
                if (pix < 0)
                    pix = 0;
                if (pix > 255)
                    pix = 255;
                push_item(pix, addr, 1'b0);
            end
        end
        else
        begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                addr = any_known_addr();
                pix  = ($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1)
                                                   : $urandom_range(0, 255);
                push_item(pix, addr, ($urandom_range(0, 11) == 0));
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // APB register write: setup cycle, then access until pready; then a
    // read of the same register to check prdata.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd_want;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd_want = '0;
        unique case (idx)
            REG_GAIN:
            begin
                reg_shadow.gain = value[GAIN_W-1:0];
                rd_want         = 32'(value[GAIN_W-1:0]);
            end
            REG_VAR_MIN:
            begin
                reg_shadow.var_min = value[PIX_W-1:0];
                rd_want            = 32'(value[PIX_W-1:0]);
            end
            REG_VAR_MAX:
            begin
                reg_shadow.var_max = value[PIX_W-1:0];
                rd_want            = 32'(value[PIX_W-1:0]);
            end
            default:     ;
        endcase
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== rd_want)
        begin
            $error("prdata: expected %0d, got %0d", rd_want, prdata);
            mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Block is idle once nothing waits to be sent, nothing is on the bus
    // and every predicted result has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pixel_stream.size() != 0 || in_valid || pending_verdicts.size() != 0);
    endtask

    task automatic run_phase(input int g, input int vmin, input int vmax);
        write_reg(REG_GAIN, g);
        write_reg(REG_VAR_MIN, vmin);
        write_reg(REG_VAR_MAX, vmax);
        items_queued = 0;
        while (items_queued < PHASE_ITEMS)
            queue_episode();
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps, some gap-free.
    // A presented pixel holds until its transfer has happened.
    // ------------------------------------------------------------------
    bit          in_taken   = 1'b0;
    int          burst_left = 0;
    int          gap_left   = 0;
    pixel_item_t next_pixel;

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pixel_stream.size() > 0)
            begin
                next_pixel = pixel_stream.pop_front();
                pixel      <= next_pixel.pix;
                pixel_addr <= next_pixel.addr;
                init_frame <= next_pixel.init;
                in_valid   <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern switches between modes at random,
    // from never stalling to stalling most of the time.
    // ------------------------------------------------------------------
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_span = 0;

    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_span = $urandom_range(10, 60);
        end
        else
            stall_span--;
        unique case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
            default:     out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each input transfer, check each result transfer
    // against the oldest prediction, and watch for a hung pipe.
    // ------------------------------------------------------------------
    verdict_t want;
    int       stuck_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            pending_verdicts.push_back(update_background(pixel, pixel_addr, init_frame));
            in_taken = 1'b1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result transfer with no pixel outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (motion !== want.motion)
                begin
                    $error("motion: expected %0d, got %0d", want.motion, motion);
                    mismatches++;
                end
                if (abs_difference !== want.abs_difference)
                begin
                    $error("abs_difference: expected %0d, got %0d",
                           want.abs_difference, abs_difference);
                    mismatches++;
                end
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $error("no transfer for %0d cycles", STUCK_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pixels under the reset register values
        push_item(0,    16'h0000, 1'b1);   // address and pixel extremes
        push_item(255,  16'hFFFF, 1'b1);
        push_item(255,  16'h0000, 1'b0);   // gain*diff saturates
        push_item(0,    16'hFFFF, 1'b0);
        push_item(255,  16'h0000, 1'b0);   // same entry back to back
        push_item(255,  16'h0000, 1'b0);
        push_item(8'hAA, 16'h5555, 1'b1);
        push_item(8'hAA, 16'h5555, 1'b0);  // no change: variance pulled to var_min
        push_item(8'h55, 16'hAAAA, 1'b1);
        push_item(8'h56, 16'hAAAA, 1'b0);  // mean catches up, diff zero
        push_item(8'h58, 16'hAAAA, 1'b0);
        push_item(128,  16'h0000, 1'b1);   // re-initialise a used entry
        push_item(128,  16'h0000, 1'b0);
        push_item(255,  16'hFFFF, 1'b0);
        push_item(8'h0F, 16'h1234, 1'b1);
        push_item(8'hF0, 16'h1234, 1'b0);
        push_item(8'hF0, 16'h1234, 1'b0);
        push_item(8'h0F, 16'h5555, 1'b0);  // interleaved entries
        push_item(8'hF0, 16'h1234, 1'b0);
        push_item(0,    16'hFFFF, 1'b1);
        items_queued = 0;
        while (items_queued < PHASE_ITEMS)
            queue_episode();
        wait_drained();

        run_phase(15, 0, 255);     // widest clamp, largest gain
        run_phase(1, 255, 0);      // crossed bounds
        run_phase(0, 0, 255);      // zero gain, variance may reach zero
        run_phase(4, 8, 20);       // narrow clamp window
        run_phase($urandom_range(1, 15), $urandom_range(0, 100), $urandom_range(100, 255));
        run_phase(int'(GAIN_RST), int'(VAR_MIN_RST), int'(VAR_MAX_RST));

        // catch any stray result after the last expected one
        repeat (PIPE_DEPTH + 5) @(posedge clk);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/sdmd_pkg.sv
hw/rtl/sdmd_update.sv
hw/rtl/sigma_delta_motion_detect.sv
bench/tb_sigma_delta_motion_detect.sv
